>>> hw/rtl/spa_pkg.sv
package spa_pkg;

  localparam int unsigned TagBits     = 16;
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned SevBits     = 2;
  localparam int unsigned CountBits   = 4;
  localparam int unsigned DefEntries  = 8;

  // Severity codes as they arrive on the input.
  localparam logic [SevBits-1:0] SEV_WARN = 2'd1;
  localparam logic [SevBits-1:0] SEV_CRIT = 2'd2;

  typedef enum logic [1:0] {
    KIND_RAISE   = 2'd0,
    KIND_CLR_ID  = 2'd1,
    KIND_CLR_SRC = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RANK_INFO = 2'd1,
    RANK_WARN = 2'd2,
    RANK_CRIT = 2'd3
  } rank_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic [TagBits-1:0]     source_tag;
    logic [TagBits-1:0]     entry_id;
    logic [SevBits-1:0]     severity;
    logic [PayloadBits-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic                   shown_valid;
    logic [TagBits-1:0]     shown_source;
    logic [TagBits-1:0]     shown_id;
    logic [SevBits-1:0]     shown_severity;
    logic [PayloadBits-1:0] shown_payload;
    logic [CountBits-1:0]   pending_count;
    logic                   dropped;
  } out_item_t;

  // Contents of one table slot.
  typedef struct packed {
    logic [TagBits-1:0]     source;
    logic [TagBits-1:0]     id;
    logic [SevBits-1:0]     sev;
    logic [PayloadBits-1:0] payload;
  } slot_t;

  // Per-slot status seen by the rank reduction in the top level.
  typedef struct packed {
    logic valid;
    logic crit;
    logic warn;
  } cell_stat_t;

  // Broadcast from the top level to every cell during selection.
  typedef struct packed {
    rank_e              top_rank;
    logic               cur_valid;
    logic [TagBits-1:0] cur_id;
  } pick_ctl_t;

  function automatic rank_e rank_of(input logic [SevBits-1:0] sev);
    rank_e r;
    unique case (sev)
      SEV_CRIT: r = RANK_CRIT;
      SEV_WARN: r = RANK_WARN;
      default:  r = RANK_INFO;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/spa_cell.sv
module spa_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Table update
  input  logic                upd_en_i,
  input  spa_pkg::in_item_t   item_i,
  input  logic                any_hit_i,
  input  logic                prev_valid_i,
  input  logic                next_valid_i,
  input  spa_pkg::slot_t      next_slot_i,
  input  logic                hit_l_i,
  output logic                hit_l_o,
  // Selection
  input  spa_pkg::pick_ctl_t  pick_i,
  input  logic                top_l_i,
  output logic                top_l_o,
  input  logic                tm_r_i,
  output logic                tm_r_o,
  input  logic                any_tm_i,
  output logic                sel_o,
  // State
  output logic                valid_o,
  output spa_pkg::slot_t      slot_o,
  output spa_pkg::cell_stat_t stat_o
);
  import spa_pkg::*;

  logic  valid_q, valid_d;
  slot_t slot_q, slot_d;
  logic  key_match, first_hit;
  rank_e rank;
  logic  top, tm;

  // A clear by id compares the id tag; everything else compares the source tag.
  always_comb begin
    if (item_i.kind == KIND_CLR_ID) begin
      key_match = valid_q && (slot_q.id == item_i.entry_id);
    end else begin
      key_match = valid_q && (slot_q.source == item_i.source_tag);
    end
  end

  assign first_hit = key_match && !hit_l_i;
  assign hit_l_o   = hit_l_i || key_match;

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    if (upd_en_i) begin
      case (item_i.kind) inside
        KIND_RAISE: begin
          if (first_hit || (!valid_q && prev_valid_i && !any_hit_i)) begin
            valid_d = 1'b1;
            slot_d  = '{source:  item_i.source_tag,
                        id:      item_i.entry_id,
                        sev:     item_i.severity,
                        payload: item_i.payload};
          end
        end
        KIND_CLR_ID, KIND_CLR_SRC: begin
          // From the removed slot onward every slot takes its right neighbor.
          if (hit_l_o) begin
            valid_d = next_valid_i;
            slot_d  = next_slot_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // Selection: first slot of top rank, unless a top-rank slot carries the id
  // shown now, in which case the last such slot wins.
  assign rank    = rank_of(slot_q.sev);
  assign top     = valid_q && (rank == pick_i.top_rank);
  assign tm      = top && pick_i.cur_valid && (slot_q.id == pick_i.cur_id);
  assign top_l_o = top_l_i || top;
  assign tm_r_o  = tm_r_i || tm;
  assign sel_o   = any_tm_i ? (tm && !tm_r_i) : (top && !top_l_i);

  assign valid_o = valid_q;
  assign slot_o  = slot_q;
  assign stat_o  = '{valid: valid_q,
                     crit:  valid_q && (rank == RANK_CRIT),
                     warn:  valid_q && (rank == RANK_WARN)};

endmodule

>>> hw/rtl/severity_prompt_arbiter_core.sv
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_ready_o   in_item_i  (spa_pkg::in_item_t)
// out       source     out_valid_o / out_ready_i out_item_o (spa_pkg::out_item_t)
//
// The accepting edge of an item updates the row of slot cells, and the following edge
// latches the selected alert into the result register. The next transfer on the input is
// taken at the earliest in the cycle in which the result is taken, so no new item is taken
// while the last one is still in the table update or selection. Reset clears the slot
// valid bits and the shown alert to zero; slot contents are not reset.
// While a result waits with out_ready_i low, the result holds and in_ready_o stays low.
module severity_prompt_arbiter_core #(
  parameter int unsigned ENTRIES = spa_pkg::DefEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spa_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spa_pkg::out_item_t out_item_o
);
  import spa_pkg::*;

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PICK = 2'b10
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      drop_q, drop_d;
  logic      accept;

  // Neighbor chains through the row of cells. The hit and top chains run from
  // slot 0 upward, the id-match chain runs from the last slot downward.
  logic [ENTRIES:0]   hit_c;
  logic [ENTRIES:0]   top_c;
  logic [ENTRIES:0]   tm_c;
  logic [ENTRIES-1:0] valid_v;
  logic [ENTRIES-1:0] sel_v;
  logic [ENTRIES-1:0] crit_v;
  logic [ENTRIES-1:0] warn_v;
  slot_t              slot_v [ENTRIES];
  cell_stat_t         stat_v [ENTRIES];
  pick_ctl_t          pick;
  slot_t              shown;
  logic [CntW-1:0]    count;
  logic [CntW+3:0]    count_ext;

  assign hit_c[0]       = 1'b0;
  assign top_c[0]       = 1'b0;
  assign tm_c[ENTRIES]  = 1'b0;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic  prev_valid;
    logic  next_valid;
    slot_t next_slot;

    if (g == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid_v[g-1];
    end

    if (g == ENTRIES - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_slot  = '0;
    end else begin : g_inner
      assign next_valid = valid_v[g+1];
      assign next_slot  = slot_v[g+1];
    end

    spa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .upd_en_i     (accept),
      .item_i       (in_item_i),
      .any_hit_i    (hit_c[ENTRIES]),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_slot_i  (next_slot),
      .hit_l_i      (hit_c[g]),
      .hit_l_o      (hit_c[g+1]),
      .pick_i       (pick),
      .top_l_i      (top_c[g]),
      .top_l_o      (top_c[g+1]),
      .tm_r_i       (tm_c[g+1]),
      .tm_r_o       (tm_c[g]),
      .any_tm_i     (tm_c[0]),
      .sel_o        (sel_v[g]),
      .valid_o      (valid_v[g]),
      .slot_o       (slot_v[g]),
      .stat_o       (stat_v[g])
    );

    assign crit_v[g] = stat_v[g].crit;
    assign warn_v[g] = stat_v[g].warn;
  end

  // The highest rank present decides which slots compete. The shown id and
  // valid come from the result register, which still holds the last result.
  always_comb begin
    pick.cur_valid = out_q.shown_valid;
    pick.cur_id    = out_q.shown_id;
    if (|crit_v) begin
      pick.top_rank = RANK_CRIT;
    end else if (|warn_v) begin
      pick.top_rank = RANK_WARN;
    end else begin
      pick.top_rank = RANK_INFO;
    end
  end

  // At most one select is high, so an AND-OR mux picks the slot. With an
  // empty table nothing is selected and the shown fields become zero.
  always_comb begin
    shown = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      shown = shown | (sel_v[i] ? slot_v[i] : '0);
    end
  end

  // The table stays packed, so the count of valid slots is the pending count.
  assign count     = CntW'($countones(valid_v));
  assign count_ext = {4'b0000, count};

  // A raise is dropped when no slot has its source and the last slot is full.
  assign drop_d = accept ? ((in_item_i.kind == KIND_RAISE) && !hit_c[ENTRIES]
                            && valid_v[ENTRIES-1])
                         : drop_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_d       = '{shown_valid:    valid_v[0],
                        shown_source:   shown.source,
                        shown_id:       shown.id,
                        shown_severity: shown.sev,
                        shown_payload:  shown.payload,
                        pending_count:  count_ext[3:0],
                        dropped:        drop_q};
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      drop_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      drop_q      <= drop_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> hw/rtl/spa_checker.sv
module spa_checker #(
  parameter int unsigned ENTRIES = spa_pkg::DefEntries
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input spa_pkg::out_item_t out_item_o
);
  import spa_pkg::*;

  localparam logic [CountBits-1:0] FullCount = CountBits'(ENTRIES);

  // Each accepted item shows a valid result after the table update and the selection.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##2 out_valid_o)
    else $error("result did not follow an accepted item");

  // Only one item is in flight: no transfer right after an accepted one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.shown_valid) |->
      (out_item_o.pending_count == '0 && out_item_o.shown_id == '0 &&
       out_item_o.shown_source == '0 && out_item_o.shown_payload == '0))
    else $error("empty table shows a nonzero alert");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.dropped) |->
      (out_item_o.shown_valid && out_item_o.pending_count == FullCount))
    else $error("dropped raise without a full table");

endmodule

bind severity_prompt_arbiter_core spa_checker #(.ENTRIES(ENTRIES)) u_spa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
